### rtl/sctc_pkg.sv
// Shared definitions for the scan-code to character converter: queue sizing,
// scan-code constants, the three key maps and the decoder action struct.
// No dependencies.
`timescale 1ns / 1ps

package sctc_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CHAR_W      = 7;
  localparam int TABLE_LEN   = 58;
  localparam int TBL_IDX_W   = $clog2(TABLE_LEN);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Commands carried in tuser
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Scan codes of interest
  localparam logic [7:0] SC_RELEASE = 8'h80;
  localparam logic [6:0] SC_KEY_MSK = 7'h7F;
  localparam logic [7:0] SC_LSHIFT  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_CTRL    = 8'h1D;
  localparam logic [7:0] SC_ALT     = 8'h38;
  localparam logic [7:0] SC_F1      = 8'h3B;
  localparam char_t      CH_F1      = 7'h01;

  // Decoder result for one scan code
  typedef struct packed {
    logic  set_shift;
    logic  clr_shift;
    logic  tgl_alt;
    logic  push;
    char_t ch;
  } key_act_t;

  localparam char_t BASE_MAP [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam char_t SHIFT_MAP [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam char_t ALT_MAP [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h44, 7'h53, 7'h54, 7'h51,
    7'h46, 7'h47, 7'h45, 7'h48, 7'h58, 7'h48, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h43, 7'h52, 7'h59, 7'h42, 7'h4C, 7'h41, 7'h4A, 7'h4E, 7'h4D, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h27, 7'h4F, 7'h56, 7'h2F, 7'h7E,
    7'h50, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Ring pointer advance, wraps at QUEUE_DEPTH
  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) n = '0;
    else                              n = p + ptr_t'(1);
    return n;
  endfunction

endpackage

### rtl/scancode_to_char_with_fifo.sv
// Top level of the scan-code to character converter with character queue.
// Depends on sctc_pkg, sctc_keymap and sctc_ram.
`timescale 1ns / 1ps
//
// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+----------------------------------
// s_axis   | in  | s_axis_tvalid_i / tready_o | tuser: command, tdata: scan_code
// m_axis   | out | m_axis_tvalid_o / tready_i | tuser: read_valid,
//          |     |                            | tdata: read_char, has_key
//
// One transaction in per cycle while the input is ready, one result per
// transaction. Flags and queue pointers update at the accepting edge; the
// queue RAM read issued there is registered alongside the result stage,
// then passes to the output register. Reset clears flags, pointers and valid
// bits; queue contents are left unwritten. A stalled output holds the result
// stage; input keeps flowing while either of the two stages behind it has
// room.

module scancode_to_char_with_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] scan_code
  input  logic       s_axis_tuser_i,   // [0] command
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] read_char, [7] has_key
  output logic       m_axis_tuser_o    // [0] read_valid
);

  // Queue state
  sctc_pkg::ptr_t rd_ptr_q, rd_ptr_d;
  sctc_pkg::ptr_t wr_ptr_q, wr_ptr_d;
  logic           shift_q, shift_d;
  logic           alt_q, alt_d;

  // Result stage (aligned with RAM read data)
  logic s1_valid_q;
  logic s1_pop_q;
  logic s1_has_q;

  // Output register
  logic            out_valid_q;
  logic            out_rv_q;
  sctc_pkg::char_t out_char_q;
  logic            out_has_q;

  logic               accept;
  logic               is_read;
  logic               q_empty;
  logic               q_full;
  logic               do_pop;
  logic               do_push;
  logic               s1_adv;
  sctc_pkg::key_act_t act;
  sctc_pkg::char_t    ram_rdata;
  sctc_pkg::char_t    s1_char;

  sctc_keymap u_keymap (
    .scan_code_i (s_axis_tdata_i),
    .shift_i     (shift_q),
    .alt_i       (alt_q),
    .act_o       (act)
  );

  // Handshakes: result stage drains into the output register when it is
  // empty or being taken; input loads the result stage likewise.
  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_read         = (s_axis_tuser_i == sctc_pkg::CMD_READ);

  assign q_empty = (rd_ptr_q == wr_ptr_q);
  assign q_full  = (sctc_pkg::ptr_next(wr_ptr_q) == rd_ptr_q);
  assign do_pop  = accept && is_read && !q_empty;
  assign do_push = accept && !is_read && act.push && !q_full;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    shift_d  = shift_q;
    alt_d    = alt_q;
    if (do_pop)  rd_ptr_d = sctc_pkg::ptr_next(rd_ptr_q);
    if (do_push) wr_ptr_d = sctc_pkg::ptr_next(wr_ptr_q);
    if (accept && !is_read) begin
      if (act.set_shift) shift_d = 1'b1;
      if (act.clr_shift) shift_d = 1'b0;
      if (act.tgl_alt)   alt_d   = !alt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      shift_q  <= 1'b0;
      alt_q    <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      shift_q  <= shift_d;
      alt_q    <= alt_d;
    end
  end

  // Character queue; read enable only on a pop so the data holds on stall.
  // A push and a pop never share an edge, so no bypass is needed.
  sctc_ram #(
    .WIDTH (sctc_pkg::CHAR_W),
    .DEPTH (sctc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_ptr_q),
    .wdata_i (act.ch),
    .re_i    (do_pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pop_q <= do_pop;
      s1_has_q <= (rd_ptr_d != wr_ptr_d);
    end
  end

  assign s1_char = s1_pop_q ? ram_rdata : '0;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_rv_q   <= s1_pop_q;
      out_char_q <= s1_char;
      out_has_q  <= s1_has_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_rv_q;
  assign m_axis_tdata_o  = {out_has_q, out_char_q};

`ifndef SYNTHESIS
  // A queue slot is either written or read by one transaction, never both
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_push && do_pop))
    else $error("push and pop in the same cycle");

  // A successful read shows up as a pop in the result stage
  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (s1_valid_q && s1_pop_q))
    else $error("pop lost on the way to the result stage");

  // A held result stage must keep its RAM read data
  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(ram_rdata)))
    else $error("queue read data changed under a stalled result");

  // Queue never accepts a push into the last free slot
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> (wr_ptr_q != rd_ptr_q))
    else $error("queue wrapped onto itself");
`endif

endmodule

### rtl/sctc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sctc_keymap.sv
// Scan-code decoder: turns one set-1 byte plus the shift/alt flags into
// flag updates and an optional character to queue. Uses sctc_pkg.
`timescale 1ns / 1ps

module sctc_keymap (
  input  logic              [7:0] scan_code_i,
  input  logic                    shift_i,
  input  logic                    alt_i,
  output sctc_pkg::key_act_t      act_o
);

  logic [6:0]                     key;
  logic [sctc_pkg::TBL_IDX_W-1:0] idx;
  sctc_pkg::char_t                map_ch;
  logic                           in_table;

  assign key      = scan_code_i[6:0] & sctc_pkg::SC_KEY_MSK;
  assign idx      = scan_code_i[sctc_pkg::TBL_IDX_W-1:0];
  assign in_table = ({24'd0, scan_code_i} < 32'(sctc_pkg::TABLE_LEN));

  always_comb begin
    map_ch = '0;
    if (in_table) begin
      if (alt_i)        map_ch = sctc_pkg::ALT_MAP[idx];
      else if (shift_i) map_ch = sctc_pkg::SHIFT_MAP[idx];
      else              map_ch = sctc_pkg::BASE_MAP[idx];
    end
  end

  always_comb begin
    act_o = '0;
    if ((scan_code_i & sctc_pkg::SC_RELEASE) != 8'd0) begin
      // release: only the shift keys matter
      if ({1'b0, key} == sctc_pkg::SC_LSHIFT || {1'b0, key} == sctc_pkg::SC_RSHIFT) begin
        act_o.clr_shift = 1'b1;
      end
    end else if (scan_code_i == sctc_pkg::SC_LSHIFT ||
                 scan_code_i == sctc_pkg::SC_RSHIFT) begin
      act_o.set_shift = 1'b1;
    end else if (scan_code_i == sctc_pkg::SC_CTRL) begin
      act_o = '0;
    end else if (scan_code_i == sctc_pkg::SC_ALT) begin
      act_o.tgl_alt = 1'b1;
    end else if (scan_code_i == sctc_pkg::SC_F1) begin
      act_o.push = 1'b1;
      act_o.ch   = sctc_pkg::CH_F1;
    end else begin
      act_o.push = (map_ch != '0);
      act_o.ch   = map_ch;
    end
  end

endmodule
